>>> hdl/single_source_shortest_path_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shortest path block
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SINGLE_SOURCE_SHORTEST_PATH_TOP_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge out of reset
`define SSSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
// Check that a trigger is followed by a condition in the next cycle
`define SSSP_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("%m: check failed");
`else
`define SSSP_ASSERT(lbl, prop)
`define SSSP_ASSERT_NEXT(lbl, trig, cond)
`endif

`endif

>>> hdl/sssp_pkg.sv
// ----------------------------------------------------------------------------
// Shortest path package
// Widths, codes, sequencer states and shared structs of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package sssp_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = 6;
  localparam int CNT_W     = 7;
  localparam int WEIGHT_W  = 16;
  localparam int DIST_W    = 22;
  localparam int WADDR_W   = 2 * NODE_W;
  localparam int NTAB_W    = NODE_W + DIST_W;

  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_NODES);
  localparam logic [CNT_W-1:0]  CNT_MIN   = CNT_W'(1);

  // Request kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Configuration register indexes
  localparam logic CFG_NODE_COUNT  = 1'b0;
  localparam logic CFG_SOURCE_NODE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SEL,
    ST_RLX,
    ST_O_RD,
    ST_O_FW,
    ST_O_BW,
    ST_O_EMIT
  } state_t;

  // Operands of the shared add/compare unit
  typedef struct packed {
    logic [DIST_W-1:0]   a;
    logic [WEIGHT_W-1:0] b;
    logic [DIST_W-1:0]   c;
  } alu_req_t;

  typedef struct packed {
    logic [DIST_W-1:0] sum;
    logic              lt;
  } alu_rsp_t;

  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic [DIST_W-1:0]   distance;
    logic                reachable;
    logic                has_predecessor;
    logic [NODE_W-1:0]   predecessor;
    logic [WEIGHT_W-1:0] forward_weight;
    logic [WEIGHT_W-1:0] backward_weight;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/single_source_shortest_path_top.sv
// ----------------------------------------------------------------------------
// Single-source shortest path engine
// Dijkstra over a loaded weight matrix with one shared add/compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. A load request
//   (in_kind = 0) writes in_weight at matrix entry in_row -> in_col in that
//   same cycle; busy stays low, so loads go one per cycle. A start request
//   (in_kind = 1) runs the search from source_node over node_count nodes and
//   raises busy until the last result is out.
//   Configuration writes use cfg_valid/cfg_ready (ready is always high):
//   index 0 is node_count, index 1 is source_node. Write them while idle.
//   Results come one per node in index order, each on the out_ ports for one
//   cycle with out_valid high; out_last marks the final node. The receiver
//   cannot stall, so results are never held.
//   Each select and relax scan reads one node table entry per cycle through the
//   single add/compare unit; output steps through the read, forward weight,
//   backward weight and emit states per node for its two weight memory reads.
//   Reset clears the flags and the configuration (64 nodes, source 0); the
//   weight matrix keeps no reset value and must be loaded before start.
// ----------------------------------------------------------------------------
`default_nettype none

module single_source_shortest_path_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output      logic                             busy,
  input  wire logic                             in_kind,
  input  wire logic [sssp_pkg::NODE_W-1:0]      in_row,
  input  wire logic [sssp_pkg::NODE_W-1:0]      in_col,
  input  wire logic [sssp_pkg::WEIGHT_W-1:0]    in_weight,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic                             cfg_index,
  input  wire logic [sssp_pkg::CNT_W-1:0]       cfg_data,
  output      logic                             out_valid,
  output      logic [sssp_pkg::NODE_W-1:0]      out_node,
  output      logic [sssp_pkg::DIST_W-1:0]      out_distance,
  output      logic                             out_reachable,
  output      logic                             out_has_predecessor,
  output      logic [sssp_pkg::NODE_W-1:0]      out_predecessor,
  output      logic [sssp_pkg::WEIGHT_W-1:0]    out_forward_weight,
  output      logic [sssp_pkg::WEIGHT_W-1:0]    out_backward_weight,
  output      logic                             out_last
);

  logic [sssp_pkg::CNT_W-1:0]    node_count_r, node_count_nxt;
  logic [sssp_pkg::NODE_W-1:0]   source_node_r, source_node_nxt;
  logic                          wmem_we;
  logic [sssp_pkg::WADDR_W-1:0]  wmem_raddr;
  logic [sssp_pkg::WEIGHT_W-1:0] wmem_rdata;
  sssp_pkg::alu_req_t            alu_req;
  sssp_pkg::alu_rsp_t            alu_rsp;
  sssp_pkg::result_t             res;

  // Configuration register writes
  always_comb begin
    node_count_nxt  = node_count_r;
    source_node_nxt = source_node_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        sssp_pkg::CFG_NODE_COUNT:  node_count_nxt  = cfg_data;
        sssp_pkg::CFG_SOURCE_NODE: source_node_nxt = cfg_data[sssp_pkg::NODE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= sssp_pkg::CNT_MAX;
      source_node_r <= '0;
    end else begin
      node_count_r  <= node_count_nxt;
      source_node_r <= source_node_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  // Load requests write the matrix directly
  assign wmem_we = start && !busy && (in_kind == sssp_pkg::KIND_LOAD);

  sssp_wmem u_wmem (
    .clk   (clk),
    .we    (wmem_we),
    .waddr ({in_row, in_col}),
    .wdata (in_weight),
    .raddr (wmem_raddr),
    .rdata (wmem_rdata)
  );

  sssp_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  sssp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_kind     (in_kind),
    .busy        (busy),
    .node_count  (node_count_r),
    .source_node (source_node_r),
    .wmem_raddr  (wmem_raddr),
    .wmem_rdata  (wmem_rdata),
    .alu_req     (alu_req),
    .alu_rsp     (alu_rsp),
    .res_valid   (out_valid),
    .res         (res)
  );

  // Unpack the result
  assign out_node            = res.node;
  assign out_distance        = res.distance;
  assign out_reachable       = res.reachable;
  assign out_has_predecessor = res.has_predecessor;
  assign out_predecessor     = res.predecessor;
  assign out_forward_weight  = res.forward_weight;
  assign out_backward_weight = res.backward_weight;
  assign out_last            = res.last;

endmodule

`default_nettype wire

>>> hdl/sssp_wmem.sv
// ----------------------------------------------------------------------------
// Weight matrix memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sssp_wmem (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [sssp_pkg::WADDR_W-1:0]    waddr,
  input  wire logic [sssp_pkg::WEIGHT_W-1:0]   wdata,
  input  wire logic [sssp_pkg::WADDR_W-1:0]    raddr,
  output      logic [sssp_pkg::WEIGHT_W-1:0]   rdata
);

  logic [sssp_pkg::WEIGHT_W-1:0] mem [sssp_pkg::MAX_NODES*sssp_pkg::MAX_NODES];
  logic [sssp_pkg::WEIGHT_W-1:0] rdata_r;

  // Write one weight, read one weight
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hdl/sssp_alu.sv
// ----------------------------------------------------------------------------
// Shared add and compare unit
// Saturating distance plus weight, then a less-than against a stored distance.
// ----------------------------------------------------------------------------
`default_nettype none

module sssp_alu (
  input  wire sssp_pkg::alu_req_t req,
  output      sssp_pkg::alu_rsp_t rsp
);

  logic [sssp_pkg::DIST_W:0]   sum_full;
  logic [sssp_pkg::DIST_W-1:0] sum_sat;

  // Add, clamp to the largest distance, compare
  always_comb begin
    sum_full = {1'b0, req.a} + (sssp_pkg::DIST_W+1)'(req.b);
    sum_sat  = sum_full[sssp_pkg::DIST_W] ? sssp_pkg::DIST_MAX
                                           : sum_full[sssp_pkg::DIST_W-1:0];
    rsp.sum  = sum_sat;
    rsp.lt   = (sum_sat < req.c);
  end

endmodule

`default_nettype wire

>>> hdl/sssp_ctrl.sv
// ----------------------------------------------------------------------------
// Search sequencer
// Runs select and relax scans over the node table, then emits one result per node.
// ----------------------------------------------------------------------------
`default_nettype none
`include "single_source_shortest_path_top_assert.svh"

module sssp_ctrl (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic                               in_kind,
  output      logic                               busy,
  input  wire logic [sssp_pkg::CNT_W-1:0]         node_count,
  input  wire logic [sssp_pkg::NODE_W-1:0]        source_node,
  output      logic [sssp_pkg::WADDR_W-1:0]       wmem_raddr,
  input  wire logic [sssp_pkg::WEIGHT_W-1:0]      wmem_rdata,
  output      sssp_pkg::alu_req_t                 alu_req,
  input  wire sssp_pkg::alu_rsp_t                 alu_rsp,
  output      logic                               res_valid,
  output      sssp_pkg::result_t                  res
);

  localparam int NW = sssp_pkg::NODE_W;
  localparam int DW = sssp_pkg::DIST_W;
  localparam int CW = sssp_pkg::CNT_W;
  localparam int MN = sssp_pkg::MAX_NODES;

  sssp_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [NW-1:0]  pidx_r, pidx_nxt;
  logic           pv_r, pv_nxt;
  logic           found_r, found_nxt;
  logic [NW-1:0]  cur_r, cur_nxt;
  logic [DW-1:0]  best_r, best_nxt;
  logic [MN-1:0]  reached_r, reached_nxt;
  logic [MN-1:0]  settled_r, settled_nxt;
  logic [MN-1:0]  haspred_r, haspred_nxt;
  logic [DW-1:0]  o_dist_r, o_dist_nxt;
  logic [NW-1:0]  o_pred_r, o_pred_nxt;
  logic [sssp_pkg::WEIGHT_W-1:0] o_fw_r, o_fw_nxt;
  sssp_pkg::result_t res_r, res_nxt;
  logic           res_valid_r, res_valid_nxt;

  // Node table: predecessor over distance
  logic [sssp_pkg::NTAB_W-1:0] ntab_mem [MN];
  logic [sssp_pkg::NTAB_W-1:0] ntab_q_r;
  logic                        ntab_we;
  logic [NW-1:0]               ntab_waddr;
  logic [sssp_pkg::NTAB_W-1:0] ntab_wdata;
  logic [NW-1:0]               ntab_raddr;
  logic [DW-1:0]               ntab_dist;
  logic [NW-1:0]               ntab_pred;

  logic           issue;
  logic           p_last;
  logic           found_upd;
  logic [NW-1:0]  cur_upd;
  logic [DW-1:0]  best_upd;
  logic [CW-1:0]  cnt_eff;

  assign ntab_dist = ntab_q_r[DW-1:0];
  assign ntab_pred = ntab_q_r[sssp_pkg::NTAB_W-1:DW];

  // Node table write and registered read
  always_ff @(posedge clk) begin
    if (ntab_we) begin
      ntab_mem[ntab_waddr] <= ntab_wdata;
    end
    ntab_q_r <= ntab_mem[ntab_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sssp_pkg::ST_IDLE;
      cnt_r       <= sssp_pkg::CNT_MAX;
      idx_r       <= '0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      reached_r   <= '0;
      settled_r   <= '0;
      haspred_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      pv_r        <= pv_nxt;
      found_r     <= found_nxt;
      reached_r   <= reached_nxt;
      settled_r   <= settled_nxt;
      haspred_r   <= haspred_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    pidx_r   <= pidx_nxt;
    cur_r    <= cur_nxt;
    best_r   <= best_nxt;
    o_dist_r <= o_dist_nxt;
    o_pred_r <= o_pred_nxt;
    o_fw_r   <= o_fw_nxt;
    res_r    <= res_nxt;
  end

  // Clamp the requested node count into the supported range
  always_comb begin
    priority if (node_count == '0) begin
      cnt_eff = sssp_pkg::CNT_MIN;
    end else if (node_count > sssp_pkg::CNT_MAX) begin
      cnt_eff = sssp_pkg::CNT_MAX;
    end else begin
      cnt_eff = node_count;
    end
  end

  assign issue  = (idx_r < cnt_r);
  assign p_last = pv_r && ({1'b0, pidx_r} == (cnt_r - CW'(1)));

  // Sequencer: next state, table updates and shared unit operands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pidx_nxt      = pidx_r;
    pv_nxt        = 1'b0;
    found_nxt     = found_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    reached_nxt   = reached_r;
    settled_nxt   = settled_r;
    haspred_nxt   = haspred_r;
    o_dist_nxt    = o_dist_r;
    o_pred_nxt    = o_pred_r;
    o_fw_nxt      = o_fw_r;
    res_nxt       = res_r;
    res_valid_nxt = 1'b0;
    ntab_we       = 1'b0;
    ntab_waddr    = pidx_r;
    ntab_wdata    = {cur_r, alu_rsp.sum};
    ntab_raddr    = idx_r[NW-1:0];
    wmem_raddr    = {cur_r, idx_r[NW-1:0]};
    alu_req.a     = ntab_dist;
    alu_req.b     = '0;
    alu_req.c     = best_r;
    found_upd     = found_r;
    cur_upd       = cur_r;
    best_upd      = best_r;

    unique case (state_r)
      sssp_pkg::ST_IDLE: begin
        // Take a start request; loads go straight to the weight memory
        if (start && (in_kind == sssp_pkg::KIND_START)) begin
          cnt_nxt     = cnt_eff;
          reached_nxt = '0;
          settled_nxt = '0;
          haspred_nxt = '0;
          state_nxt   = sssp_pkg::ST_INIT;
        end
      end

      sssp_pkg::ST_INIT: begin
        // Seed the source at distance zero, or report nothing reached
        idx_nxt   = '0;
        found_nxt = 1'b0;
        if ({1'b0, source_node} < cnt_r) begin
          reached_nxt[source_node] = 1'b1;
          ntab_we    = 1'b1;
          ntab_waddr = source_node;
          ntab_wdata = '0;
          state_nxt  = sssp_pkg::ST_SEL;
        end else begin
          state_nxt  = sssp_pkg::ST_O_RD;
        end
      end

      sssp_pkg::ST_SEL: begin
        // Scan for the open node of least distance, lowest index on ties
        if (issue) begin
          idx_nxt = idx_r + CW'(1);
        end
        pv_nxt   = issue;
        pidx_nxt = idx_r[NW-1:0];
        if (pv_r && reached_r[pidx_r] && !settled_r[pidx_r] &&
            (!found_r || alu_rsp.lt)) begin
          found_upd = 1'b1;
          cur_upd   = pidx_r;
          best_upd  = ntab_dist;
        end
        found_nxt = found_upd;
        cur_nxt   = cur_upd;
        best_nxt  = best_upd;
        if (p_last) begin
          pv_nxt  = 1'b0;
          idx_nxt = '0;
          if (found_upd) begin
            settled_nxt[cur_upd] = 1'b1;
            state_nxt = sssp_pkg::ST_RLX;
          end else begin
            state_nxt = sssp_pkg::ST_O_RD;
          end
        end
      end

      sssp_pkg::ST_RLX: begin
        // Relax the edges out of the node just settled
        alu_req.a = best_r;
        alu_req.b = wmem_rdata;
        alu_req.c = ntab_dist;
        if (issue) begin
          idx_nxt = idx_r + CW'(1);
        end
        pv_nxt   = issue;
        pidx_nxt = idx_r[NW-1:0];
        if (pv_r && (wmem_rdata != '0) && !settled_r[pidx_r] &&
            (!reached_r[pidx_r] || alu_rsp.lt)) begin
          ntab_we              = 1'b1;
          reached_nxt[pidx_r]  = 1'b1;
          haspred_nxt[pidx_r]  = 1'b1;
        end
        if (p_last) begin
          pv_nxt    = 1'b0;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = sssp_pkg::ST_SEL;
        end
      end

      sssp_pkg::ST_O_RD: begin
        // Fetch distance and predecessor of the node
        state_nxt = sssp_pkg::ST_O_FW;
      end

      sssp_pkg::ST_O_FW: begin
        // Hold the table entry, fetch the predecessor-to-node weight
        o_dist_nxt = ntab_dist;
        o_pred_nxt = ntab_pred;
        wmem_raddr = {ntab_pred, idx_r[NW-1:0]};
        state_nxt  = sssp_pkg::ST_O_BW;
      end

      sssp_pkg::ST_O_BW: begin
        // Hold the forward weight, fetch the node-to-predecessor weight
        o_fw_nxt   = wmem_rdata;
        wmem_raddr = {idx_r[NW-1:0], o_pred_r};
        state_nxt  = sssp_pkg::ST_O_EMIT;
      end

      sssp_pkg::ST_O_EMIT: begin
        // Register one result and advance to the next node
        res_valid_nxt       = 1'b1;
        res_nxt.node        = idx_r[NW-1:0];
        res_nxt.reachable   = reached_r[idx_r[NW-1:0]];
        res_nxt.distance    = reached_r[idx_r[NW-1:0]] ? o_dist_r : '0;
        res_nxt.has_predecessor = haspred_r[idx_r[NW-1:0]];
        res_nxt.predecessor     = haspred_r[idx_r[NW-1:0]] ? o_pred_r : '0;
        res_nxt.forward_weight  = haspred_r[idx_r[NW-1:0]] ? o_fw_r : '0;
        res_nxt.backward_weight = haspred_r[idx_r[NW-1:0]] ? wmem_rdata : '0;
        res_nxt.last        = (idx_r == (cnt_r - CW'(1)));
        if (idx_r == (cnt_r - CW'(1))) begin
          idx_nxt   = '0;
          state_nxt = sssp_pkg::ST_IDLE;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = sssp_pkg::ST_O_RD;
        end
      end
    endcase
  end

  assign busy      = (state_r != sssp_pkg::ST_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // Checks
  `SSSP_ASSERT(a_strobe_after_emit, res_valid_r |-> $past(state_r == sssp_pkg::ST_O_EMIT))
  `SSSP_ASSERT(a_last_has_strobe, res_r.last && res_valid_r |-> res_valid_r && !busy)
  `SSSP_ASSERT(a_settled_reached, (settled_r & ~reached_r) == '0)
  `SSSP_ASSERT(a_pred_reached, (haspred_r & ~reached_r) == '0)
  `SSSP_ASSERT_NEXT(a_start_busy, start && !busy && in_kind == sssp_pkg::KIND_START, busy)

endmodule

`default_nettype wire

>>> tb/tb_single_source_shortest_path_top.sv
// ----------------------------------------------------------------------------
// Shortest path engine testbench
// Loads weight matrices, runs searches under several node counts and sources,
// and checks every per-node result against a local Dijkstra predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_single_source_shortest_path_top;

  import sssp_pkg::*;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int ITEM_TARGET    = 210;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_START} row_op_t;

  typedef struct {
    row_op_t             op;
    logic                reg_sel;
    logic [CNT_W-1:0]    reg_data;
    logic [NODE_W-1:0]   row;
    logic [NODE_W-1:0]   col;
    logic [WEIGHT_W-1:0] weight;
    bit                  typed;
    result_t             want;
  } script_row_t;

  localparam result_t NO_RESULT      = '0;
  localparam result_t SOLO_REACHED   = '{6'd0, 22'd0, 1'b1, 1'b0, 6'd0, 16'd0, 16'd0, 1'b1};
  localparam result_t SOLO_UNREACHED = '{6'd0, 22'd0, 1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 1'b1};

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  logic                  in_kind   = KIND_LOAD;
  logic [NODE_W-1:0]     in_row    = '0;
  logic [NODE_W-1:0]     in_col    = '0;
  logic [WEIGHT_W-1:0]   in_weight = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = CFG_NODE_COUNT;
  logic [CNT_W-1:0]      cfg_data  = '0;
  logic                  out_valid;
  logic [NODE_W-1:0]     out_node;
  logic [DIST_W-1:0]     out_distance;
  logic                  out_reachable;
  logic                  out_has_predecessor;
  logic [NODE_W-1:0]     out_predecessor;
  logic [WEIGHT_W-1:0]   out_forward_weight;
  logic [WEIGHT_W-1:0]   out_backward_weight;
  logic                  out_last;

  // Predictor copy of the block state
  logic [WEIGHT_W-1:0]   weights [MAX_NODES][MAX_NODES];
  bit                    loaded  [MAX_NODES][MAX_NODES];
  logic [CNT_W-1:0]      node_count_reg = 7'd64;
  logic [NODE_W-1:0]     source_reg     = '0;

  result_t               path_results_due [$];
  int                    mismatch_count = 0;
  int                    idle_cycles    = 0;
  int                    burst_left     = 0;
  int                    items_sent     = 0;

  // Directed requests: corner configurations, tie and strict-improvement graph
  script_row_t directed_rows [26] = '{
    '{ROW_CFG,   CFG_NODE_COUNT,  7'd1,    6'd0,  6'd0,  16'd0,     1'b0, NO_RESULT},
    '{ROW_CFG,   CFG_SOURCE_NODE, 7'd0,    6'd0,  6'd0,  16'd0,     1'b0, NO_RESULT},
    '{ROW_LOAD,  CFG_NODE_COUNT,  7'd0,    6'd0,  6'd0,  16'hFFFF,  1'b0, NO_RESULT},
    '{ROW_START, CFG_NODE_COUNT,  7'd0,    6'd0,  6'd0,  16'd0,     1'b1, SOLO_REACHED},
    '{ROW_CFG,   CFG_SOURCE_NODE, 7'h45,   6'd0,  6'd0,  16'd0,     1'b0, NO_RESULT},
    '{ROW_START, CFG_NODE_COUNT,  7'd0,    6'd63, 6'd63, 16'hFFFF,  1'b1, SOLO_UNREACHED},
    '{ROW_CFG,   CFG_NODE_COUNT,  7'd0,    6'd0,  6'd0,  16'd0,     1'b0, NO_RESULT},
    '{ROW_CFG,   CFG_SOURCE_NODE, 7'h40,   6'd0,  6'd0,  16'd0,     1'b0, NO_RESULT},
    '{ROW_START, CFG_NODE_COUNT,  7'd0,    6'd0,  6'd0,  16'd0,     1'b1, SOLO_REACHED},
    '{ROW_CFG,   CFG_NODE_COUNT,  7'd2,    6'd0,  6'd0,  16'd0,     1'b0, NO_RESULT},
    '{ROW_LOAD,  CFG_NODE_COUNT,  7'd0,    6'd0,  6'd1,  16'hFFFF,  1'b0, NO_RESULT},
    '{ROW_LOAD,  CFG_NODE_COUNT,  7'd0,    6'd1,  6'd0,  16'd1,     1'b0, NO_RESULT},
    '{ROW_LOAD,  CFG_NODE_COUNT,  7'd0,    6'd1,  6'd1,  16'd0,     1'b0, NO_RESULT},
    '{ROW_START, CFG_NODE_COUNT,  7'd0,    6'd0,  6'd0,  16'd0,     1'b0, NO_RESULT},
    '{ROW_CFG,   CFG_NODE_COUNT,  7'd3,    6'd0,  6'd0,  16'd0,     1'b0, NO_RESULT},
    '{ROW_CFG,   CFG_SOURCE_NODE, 7'd2,    6'd0,  6'd0,  16'd0,     1'b0, NO_RESULT},
    '{ROW_LOAD,  CFG_NODE_COUNT,  7'd0,    6'd0,  6'd2,  16'd7,     1'b0, NO_RESULT},
    '{ROW_LOAD,  CFG_NODE_COUNT,  7'd0,    6'd1,  6'd2,  16'd0,     1'b0, NO_RESULT},
    '{ROW_LOAD,  CFG_NODE_COUNT,  7'd0,    6'd2,  6'd2,  16'd0,     1'b0, NO_RESULT},
    '{ROW_LOAD,  CFG_NODE_COUNT,  7'd0,    6'd2,  6'd0,  16'd2,     1'b0, NO_RESULT},
    '{ROW_LOAD,  CFG_NODE_COUNT,  7'd0,    6'd2,  6'd1,  16'd5,     1'b0, NO_RESULT},
    '{ROW_LOAD,  CFG_NODE_COUNT,  7'd0,    6'd0,  6'd1,  16'd3,     1'b0, NO_RESULT},
    '{ROW_START, CFG_NODE_COUNT,  7'd0,    6'd0,  6'd0,  16'd0,     1'b0, NO_RESULT},
    '{ROW_LOAD,  CFG_NODE_COUNT,  7'd0,    6'd63, 6'd63, 16'd0,     1'b0, NO_RESULT},
    '{ROW_LOAD,  CFG_NODE_COUNT,  7'd0,    6'd42, 6'd21, 16'hAAAA,  1'b0, NO_RESULT},
    '{ROW_LOAD,  CFG_NODE_COUNT,  7'd0,    6'd21, 6'd42, 16'h5555,  1'b0, NO_RESULT}
  };

  single_source_shortest_path_top uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_row              (in_row),
    .in_col              (in_col),
    .in_weight           (in_weight),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_node            (out_node),
    .out_distance        (out_distance),
    .out_reachable       (out_reachable),
    .out_has_predecessor (out_has_predecessor),
    .out_predecessor     (out_predecessor),
    .out_forward_weight  (out_forward_weight),
    .out_backward_weight (out_backward_weight),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Clamp the node count register to the number of nodes searched
  function automatic int nodes_used(input logic [CNT_W-1:0] count);
    if (count == 0) return 1;
    if (count > MAX_NODES) return MAX_NODES;
    return int'(count);
  endfunction

  // Favor absent and short edges, with some full-range and maximal ones
  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      4, 5, 6:    return WEIGHT_W'($urandom_range(1, 20));
      7, 8:       return WEIGHT_W'($urandom);
      default:    return '1;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Run Dijkstra on the local matrix and queue one result per node
  task automatic solve_paths();
    int                  n;
    int                  cur;
    bit                  found;
    longint unsigned     sum;
    logic [DIST_W-1:0]   span     [MAX_NODES];
    logic [NODE_W-1:0]   pred     [MAX_NODES];
    bit                  reached  [MAX_NODES];
    bit                  has_pred [MAX_NODES];
    bit                  settled  [MAX_NODES];
    result_t             r;
    n = nodes_used(node_count_reg);
    for (int i = 0; i < MAX_NODES; i++) begin
      span[i]     = '0;
      pred[i]     = '0;
      reached[i]  = 1'b0;
      has_pred[i] = 1'b0;
      settled[i]  = 1'b0;
    end
    if (int'(source_reg) < n) begin
      reached[source_reg] = 1'b1;
      for (int round = 0; round < n; round++) begin
        // settle the nearest open node, lowest index on ties
        found = 1'b0;
        cur   = 0;
        for (int i = 0; i < n; i++) begin
          if (reached[i] && !settled[i] && (!found || span[i] < span[cur])) begin
            cur   = i;
            found = 1'b1;
          end
        end
        if (!found) break;
        settled[cur] = 1'b1;
        // relax edges into open nodes, replacing only on strict improvement
        for (int i = 0; i < n; i++) begin
          if (weights[cur][i] == 0 || settled[i]) continue;
          sum = 64'(span[cur]) + 64'(weights[cur][i]);
          if (sum > 64'(DIST_MAX)) sum = 64'(DIST_MAX);
          if (!reached[i] || sum < 64'(span[i])) begin
            span[i]     = DIST_W'(sum);
            reached[i]  = 1'b1;
            pred[i]     = NODE_W'(cur);
            has_pred[i] = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.node            = NODE_W'(i);
      r.distance        = reached[i] ? span[i] : '0;
      r.reachable       = reached[i];
      r.has_predecessor = has_pred[i];
      r.predecessor     = has_pred[i] ? pred[i] : '0;
      r.forward_weight  = has_pred[i] ? weights[pred[i]][i] : '0;
      r.backward_weight = has_pred[i] ? weights[i][pred[i]] : '0;
      r.last            = (i == n - 1);
      path_results_due.insert(path_results_due.size(), r);
    end
  endtask

  // Hold a request on the ports until the block takes it, then predict
  task automatic issue(input logic kind, input logic [NODE_W-1:0] r,
                       input logic [NODE_W-1:0] c, input logic [WEIGHT_W-1:0] w,
                       input bit typed, input result_t want);
    start     <= 1'b1;
    in_kind   <= kind;
    in_row    <= r;
    in_col    <= c;
    in_weight <= w;
    do @(posedge clk); while (busy);
    items_sent++;
    if (kind == KIND_LOAD) begin
      weights[r][c] = w;
      loaded[r][c]  = 1'b1;
    end else if (typed) begin
      path_results_due.insert(path_results_due.size(), want);
    end else begin
      solve_paths();
    end
  endtask

  // Send in bursts; open a gap of random length between bursts
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Drop start and wait until every queued result is out and the block is idle
  task automatic wait_idle();
    start <= 1'b0;
    while (path_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_register(input logic sel, input logic [CNT_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (sel == CFG_NODE_COUNT) node_count_reg = data;
    else source_reg = data[NODE_W-1:0];
  endtask

  // Load every entry of the block in use that was never written
  task automatic fill_matrix(input int n);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (!loaded[r][c]) begin
          pace();
          issue(KIND_LOAD, NODE_W'(r), NODE_W'(c), pick_weight(), 1'b0, NO_RESULT);
        end
      end
    end
  endtask

  initial begin : stimulus
    int                phase;
    int                n;
    int                steps;
    int                pick;
    logic [CNT_W-1:0]  count_data;
    logic [CNT_W-1:0]  source_data;
    script_row_t       step;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (directed_rows[k]) begin
      step = directed_rows[k];
      case (step.op)
        ROW_CFG:  write_register(step.reg_sel, step.reg_data);
        ROW_LOAD: begin
          pace();
          issue(KIND_LOAD, step.row, step.col, step.weight, 1'b0, NO_RESULT);
        end
        default: begin
          pace();
          issue(KIND_START, step.row, step.col, step.weight, step.typed, step.want);
        end
      endcase
    end

    // random phases: new configuration, load what the search reads, then mixed requests
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0:       count_data = ($urandom_range(0, 1) == 0) ? 7'd64 : 7'd127;
        1:       count_data = 7'd0;
        default: count_data = CNT_W'($urandom_range(2, 6));
      endcase
      n = nodes_used(count_data);
      if ($urandom_range(0, 6) == 0)
        source_data = CNT_W'($urandom_range(0, 127));
      else
        source_data = {1'($urandom_range(0, 1)), NODE_W'($urandom_range(0, n - 1))};
      write_register(CFG_NODE_COUNT, count_data);
      write_register(CFG_SOURCE_NODE, source_data);

      if (n == MAX_NODES) begin
        // full node range: clear the source row so the search reads only that row
        for (int c = 0; c < MAX_NODES; c++) begin
          pace();
          issue(KIND_LOAD, source_data[NODE_W-1:0], NODE_W'(c), '0, 1'b0, NO_RESULT);
        end
        steps = 0;
      end else begin
        fill_matrix(n);
        steps = $urandom_range(8, 16);
      end

      for (int k = 0; k < steps && items_sent < ITEM_TARGET - 1; k++) begin
        pace();
        pick = $urandom_range(0, 9);
        if (pick < 6)
          issue(KIND_LOAD, NODE_W'($urandom_range(0, n - 1)),
                NODE_W'($urandom_range(0, n - 1)), pick_weight(), 1'b0, NO_RESULT);
        else if (pick < 7)
          issue(KIND_LOAD, NODE_W'($urandom), NODE_W'($urandom), pick_weight(),
                1'b0, NO_RESULT);
        else
          issue(KIND_START, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom),
                1'b0, NO_RESULT);
      end
      pace();
      issue(KIND_START, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom),
            1'b0, NO_RESULT);
      phase++;
    end

    // drain and let the block settle
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Compare each result with the oldest queued prediction
  always @(posedge clk) begin : check_results
    result_t due;
    if (rst_n && out_valid) begin
      if (path_results_due.size() == 0) begin
        report_mismatch("unexpected result for node", out_node, 0);
      end else begin
        due = path_results_due.pop_front();
        if (out_node !== due.node)
          report_mismatch("node", out_node, due.node);
        if (out_distance !== due.distance)
          report_mismatch("distance", out_distance, due.distance);
        if (out_reachable !== due.reachable)
          report_mismatch("reachable", out_reachable, due.reachable);
        if (out_has_predecessor !== due.has_predecessor)
          report_mismatch("has_predecessor", out_has_predecessor, due.has_predecessor);
        if (out_predecessor !== due.predecessor)
          report_mismatch("predecessor", out_predecessor, due.predecessor);
        if (out_forward_weight !== due.forward_weight)
          report_mismatch("forward_weight", out_forward_weight, due.forward_weight);
        if (out_backward_weight !== due.backward_weight)
          report_mismatch("backward_weight", out_backward_weight, due.backward_weight);
        if (out_last !== due.last)
          report_mismatch("last", out_last, due.last);
      end
    end
  end

  // End the run when no request, result or register write moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
